// File: hdl/tsolv_pkg.sv
// shared types, constants and the saturation helper for the tridiagonal solver
// no dependencies
`default_nettype none

package tsolv_pkg;

    localparam int DATA_W         = 32;
    localparam int ROW_W          = 6;
    localparam int WIDE_W         = 66;
    localparam int MAX_ROWS_DEF   = 64;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [DATA_W-1:0] VMAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] VMIN = 32'h8000_0000;

    // status and result of the shared divider
    typedef struct packed {
        logic              done;
        logic              err;
        logic [DATA_W-1:0] quot;
    } t_div_res;

    // clamp a wide signed value to 32 bits, top bit flags saturation
    function automatic logic [DATA_W:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic [DATA_W:0] res;
        if (v > $signed({{(WIDE_W-DATA_W){1'b0}}, VMAX})) begin
            res = {1'b1, VMAX};
        end else if (v < $signed({{(WIDE_W-DATA_W){1'b1}}, VMIN})) begin
            res = {1'b1, VMIN};
        end else begin
            res = {1'b0, v[DATA_W-1:0]};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: hdl/tsolv_if.sv
// valid/ready channels for row beats in and solution beats out
// depends on tsolv_pkg
`default_nettype none

interface tsolv_row_if;
    logic                              valid;
    logic                              ready;
    logic signed [tsolv_pkg::DATA_W-1:0] sub_diag;
    logic signed [tsolv_pkg::DATA_W-1:0] main_diag;
    logic signed [tsolv_pkg::DATA_W-1:0] super_diag;
    logic signed [tsolv_pkg::DATA_W-1:0] rhs_value;
    logic                              last_row;

    modport source (output valid, sub_diag, main_diag, super_diag, rhs_value, last_row,
                    input ready);
    modport sink (input valid, sub_diag, main_diag, super_diag, rhs_value, last_row,
                  output ready);
endinterface

interface tsolv_res_if;
    logic                                valid;
    logic                                ready;
    logic [tsolv_pkg::ROW_W-1:0]         row_index;
    logic signed [tsolv_pkg::DATA_W-1:0] solution;
    logic                                last_result;
    logic                                error_seen;

    modport source (output valid, row_index, solution, last_result, error_seen,
                    input ready);
    modport sink (input valid, row_index, solution, last_result, error_seen,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/tridiagonal_system_solver.sv
// top level of the streaming tridiagonal (thomas) solver
// depends on tsolv_pkg, tsolv_if, tsolv_ram and tsolv_div
//
// usage:
//   i_row carries one row per beat: sub, main and super diagonal, right-hand
//   side (signed q16.16 by default) and last_row. o_res carries one solution
//   beat per row, from the last row down to row zero, with row_index,
//   solution, last_result (row zero) and error_seen (sticky over the system).
//   a row is taken only while i_row.ready is high; ready drops for the whole
//   time a row is worked on.
// work per row:
//   each row runs two multiply-subtract steps on one shared multiplier and two
//   divisions on the shared bit-serial divider; no new row is taken until both
//   divisions are done. the last row adds back substitution over each earlier
//   row, then the results leave while the receiver takes them.
// stall: a held result stays in the output register; emission waits on it.
// reset: synchronous active low; clears the sequencer, the row count, the
//   carried c' and d' and the error flag. the c'/d' stores need no clearing.
`default_nettype none

module tridiagonal_system_solver #(
    parameter int MAX_ROWS  = tsolv_pkg::MAX_ROWS_DEF,
    parameter int FRAC_BITS = tsolv_pkg::FRAC_BITS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    tsolv_row_if.sink    i_row,
    tsolv_res_if.source  o_res
);

    localparam int DW = tsolv_pkg::DATA_W;
    localparam int RW = tsolv_pkg::ROW_W;
    localparam int XW = tsolv_pkg::WIDE_W;
    localparam int AW = $clog2(MAX_ROWS);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_C, S_SUB_P, S_SUB_N, S_DIVC_GO, S_DIVC_WT, S_DIVD_GO,
        S_DIVD_WT, S_WRITE, S_BS_RD, S_BS_MUL, S_BS_SUB, S_EM_RD, S_EM_LD
    } t_state;

    t_state                 r_state;
    logic signed [DW-1:0]   r_a, r_b, r_c, r_d;
    logic                   r_last;
    logic [RW-1:0]          r_row;
    logic [RW-1:0]          r_idx;
    logic signed [DW-1:0]   r_pcp, r_pdp;
    logic signed [DW-1:0]   r_piv, r_num, r_cp, r_dp, r_x;
    logic signed [2*DW-1:0] r_prod;
    logic                   r_err;

    logic                   r_ov;
    logic [RW-1:0]          r_oidx;
    logic [DW-1:0]          r_osol;
    logic                   r_olast;
    logic                   r_oerr;

    logic signed [DW-1:0]   mul_p, mul_q;
    logic signed [2*DW-1:0] mul_out;
    logic signed [2*DW-1:0] prod_sh;
    logic signed [DW-1:0]   sub_base;
    logic signed [XW-1:0]   diff;
    logic [DW:0]            sat;
    logic                   div_start;
    logic [DW-1:0]          div_num;
    tsolv_pkg::t_div_res    div_res;
    logic                   cp_we, dp_we;
    logic [AW-1:0]          waddr;
    logic [DW-1:0]          dp_wdata;
    logic [DW-1:0]          cp_rd, dp_rd;
    logic                   in_acc;
    logic                   out_free;

    assign in_acc   = i_row.valid && i_row.ready;
    assign out_free = !r_ov || o_res.ready;

    // shared multiplier, operands chosen by step
    always_comb begin
        case (r_state)
            S_MUL_C:  begin mul_p = r_pcp;          mul_q = r_a; end
            S_SUB_P:  begin mul_p = r_pdp;          mul_q = r_a; end
            default:  begin mul_p = $signed(cp_rd); mul_q = r_x; end
        endcase
    end
    assign mul_out = mul_p * mul_q;

    // shared subtract and clamp of the scaled product
    assign prod_sh = r_prod >>> FRAC_BITS;
    always_comb begin
        case (r_state)
            S_SUB_P:  sub_base = r_b;
            S_SUB_N:  sub_base = r_d;
            default:  sub_base = $signed(dp_rd);
        endcase
    end
    assign diff = XW'(sub_base) - XW'(prod_sh);
    assign sat  = tsolv_pkg::sat32(diff);

    // divider hookup
    assign div_start = (r_state == S_DIVC_GO) || (r_state == S_DIVD_GO);
    assign div_num   = (r_state == S_DIVC_GO) ? r_c : r_num;

    tsolv_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_piv),
        .o_res   (div_res)
    );

    // c' and d' stores; d' entries are overwritten with x during back substitution
    assign cp_we    = (r_state == S_WRITE);
    assign dp_we    = (r_state == S_WRITE) || (r_state == S_BS_SUB);
    assign waddr    = (r_state == S_WRITE) ? r_row[AW-1:0] : r_idx[AW-1:0];
    assign dp_wdata = (r_state == S_WRITE) ? r_dp : sat[DW-1:0];

    tsolv_ram #(.WIDTH(DW), .DEPTH(MAX_ROWS)) u_cp_ram (
        .i_clk   (i_clk),
        .i_we    (cp_we),
        .i_waddr (waddr),
        .i_wdata (r_cp),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (cp_rd)
    );

    tsolv_ram #(.WIDTH(DW), .DEPTH(MAX_ROWS)) u_dp_ram (
        .i_clk   (i_clk),
        .i_we    (dp_we),
        .i_waddr (waddr),
        .i_wdata (dp_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (dp_rd)
    );

    // sequencer and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_pcp   <= '0;
            r_pdp   <= '0;
            r_err   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            // output register empties on a taken beat unless refilled
            if (r_ov && o_res.ready && !((r_state == S_EM_LD) && out_free)) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_a     <= (r_row == '0) ? '0 : i_row.sub_diag;
                        r_b     <= i_row.main_diag;
                        r_d     <= i_row.rhs_value;
                        r_last  <= i_row.last_row || (r_row == RW'(MAX_ROWS - 1));
                        r_c     <= (i_row.last_row || (r_row == RW'(MAX_ROWS - 1)))
                                   ? '0 : i_row.super_diag;
                        r_state <= S_MUL_C;
                    end
                end
                S_MUL_C: begin
                    r_prod  <= mul_out;
                    r_state <= S_SUB_P;
                end
                S_SUB_P: begin
                    r_piv   <= sat[DW-1:0];
                    r_err   <= r_err | sat[DW];
                    r_prod  <= mul_out;
                    r_state <= S_SUB_N;
                end
                S_SUB_N: begin
                    r_num   <= sat[DW-1:0];
                    r_err   <= r_err | sat[DW];
                    r_state <= S_DIVC_GO;
                end
                S_DIVC_GO: r_state <= S_DIVC_WT;
                S_DIVC_WT: begin
                    if (div_res.done) begin
                        r_cp    <= div_res.quot;
                        r_err   <= r_err | div_res.err;
                        r_state <= S_DIVD_GO;
                    end
                end
                S_DIVD_GO: r_state <= S_DIVD_WT;
                S_DIVD_WT: begin
                    if (div_res.done) begin
                        r_dp    <= div_res.quot;
                        r_err   <= r_err | div_res.err;
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_pcp <= r_cp;
                    r_pdp <= r_dp;
                    r_x   <= r_dp;
                    if (!r_last) begin
                        r_row   <= r_row + 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_row == '0) begin
                        r_idx   <= '0;
                        r_state <= S_EM_RD;
                    end else begin
                        r_idx   <= r_row - 1'b1;
                        r_state <= S_BS_RD;
                    end
                end
                S_BS_RD:  r_state <= S_BS_MUL;
                S_BS_MUL: begin
                    r_prod  <= mul_out;
                    r_state <= S_BS_SUB;
                end
                S_BS_SUB: begin
                    r_x   <= sat[DW-1:0];
                    r_err <= r_err | sat[DW];
                    if (r_idx == '0) begin
                        r_idx   <= r_row;
                        r_state <= S_EM_RD;
                    end else begin
                        r_idx   <= r_idx - 1'b1;
                        r_state <= S_BS_RD;
                    end
                end
                S_EM_RD: r_state <= S_EM_LD;
                S_EM_LD: begin
                    if (out_free) begin
                        r_ov    <= 1'b1;
                        r_oidx  <= r_idx;
                        r_osol  <= dp_rd;
                        r_olast <= (r_idx == '0);
                        r_oerr  <= r_err;
                        if (r_idx == '0) begin
                            r_row   <= '0;
                            r_pcp   <= '0;
                            r_pdp   <= '0;
                            r_err   <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx - 1'b1;
                            r_state <= S_EM_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_row.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_ov;
    assign o_res.row_index   = r_oidx;
    assign o_res.solution    = r_osol;
    assign o_res.last_result = r_olast;
    assign o_res.error_seen  = r_oerr;

    // the final beat of a system is always row zero
    a_last_is_row0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.last_result |-> o_res.row_index == '0)
        else $error("last result not on row zero");

    // a row beat closes the input until its work is done
    a_busy_after_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_row.ready)
        else $error("row accepted while busy");

    // row count stays inside the stores
    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= RW'(MAX_ROWS - 1))
        else $error("row count beyond store depth");

endmodule

`default_nettype wire

// File: hdl/tsolv_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module tsolv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hdl/tsolv_div.sv
// shared fixed-point divider, one quotient bit per cycle, saturating
// depends on tsolv_pkg
`default_nettype none

module tsolv_div #(
    parameter int FRAC_BITS = tsolv_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [tsolv_pkg::DATA_W-1:0]  i_num,
    input  wire logic [tsolv_pkg::DATA_W-1:0]  i_den,
    output tsolv_pkg::t_div_res                o_res
);

    localparam int DW = tsolv_pkg::DATA_W;
    localparam int W  = DW + FRAC_BITS;
    localparam int CW = $clog2(W + 1);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} t_state;

    t_state          r_state;
    logic [W-1:0]    r_dvd;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_dmag;
    logic            r_neg;
    logic [CW-1:0]   r_cnt;
    logic            r_done;
    logic            r_err;
    logic [DW-1:0]   r_quot;

    logic [DW-1:0]   nmag;
    logic [DW-1:0]   dmag;
    logic [DW:0]     shifted;
    logic            ge;

    // operand magnitudes and the restoring step
    assign nmag    = i_num[DW-1] ? (~i_num + 1'b1) : i_num;
    assign dmag    = i_den[DW-1] ? (~i_den + 1'b1) : i_den;
    assign shifted = {r_rem, r_dvd[W-1]};
    assign ge      = shifted >= {1'b0, r_dmag};

    // sequencer, shift registers and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_err   <= 1'b0;
        end else begin
            // done pulses after a zero divisor or the final step
            r_done <= (r_state == S_FIN)
                      || ((r_state == S_IDLE) && i_start && (i_den == '0));
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if (i_den == '0) begin
                            r_err  <= 1'b1;
                            if (i_num == '0) begin
                                r_quot <= '0;
                            end else if (i_num[DW-1]) begin
                                r_quot <= tsolv_pkg::VMIN;
                            end else begin
                                r_quot <= tsolv_pkg::VMAX;
                            end
                        end else begin
                            r_dvd   <= {nmag, {FRAC_BITS{1'b0}}};
                            r_rem   <= '0;
                            r_dmag  <= dmag;
                            r_neg   <= i_num[DW-1] ^ i_den[DW-1];
                            r_cnt   <= CW'(W);
                            r_state <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    r_rem <= ge ? DW'(shifted - {1'b0, r_dmag}) : shifted[DW-1:0];
                    r_dvd <= {r_dvd[W-2:0], ge};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_state <= S_IDLE;
                    if (r_neg) begin
                        if (r_dvd > {{(W-DW){1'b0}}, tsolv_pkg::VMIN}) begin
                            r_quot <= tsolv_pkg::VMIN;
                            r_err  <= 1'b1;
                        end else begin
                            r_quot <= ~r_dvd[DW-1:0] + 1'b1;
                            r_err  <= 1'b0;
                        end
                    end else begin
                        if (r_dvd > {{(W-DW){1'b0}}, tsolv_pkg::VMAX}) begin
                            r_quot <= tsolv_pkg::VMAX;
                            r_err  <= 1'b1;
                        end else begin
                            r_quot <= r_dvd[DW-1:0];
                            r_err  <= 1'b0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.done = r_done;
    assign o_res.err  = r_err;
    assign o_res.quot = r_quot;

endmodule

`default_nettype wire

// File: sim/tridiagonal_system_solver_tb.sv
// testbench for the streaming tridiagonal solver: directed and random systems in,
// solution beats checked against an in-bench forward sweep and back substitution
// depends on tsolv_pkg, tsolv_if and the solver rtl
`default_nettype none

module tridiagonal_system_solver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NROWS = 64;
    localparam int FRAC = 16;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
        logic               last;
    } t_row;

    typedef struct packed {
        logic [5:0]         idx;
        logic signed [31:0] x;
        logic               lastres;
        logic               err;
    } t_sol;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tsolv_row_if row_bus ();
    tsolv_res_if res_bus ();

    tridiagonal_system_solver DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_row   (row_bus.sink),
        .o_res   (res_bus.source)
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    logic signed [31:0] cp_mem [NROWS];
    logic signed [31:0] dp_mem [NROWS];
    logic signed [31:0] carry_cp, carry_dp;
    int                 rows_taken;
    bit                 sys_err;

    t_row pending_rows[$];
    t_sol expected_sols[$];

    int mismatches = 0;
    int rows_sent = 0;
    int sols_seen = 0;
    int systems_done = 0;
    int idle_cycles = 0;
    bit stimulus_done = 0;
    int hold_off = 0;

    function automatic logic signed [31:0] clamp(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            sys_err = 1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -66'sd2147483648) begin
            sys_err = 1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [65:0] fx_mul(input logic signed [31:0] p,
                                                  input logic signed [31:0] q);
        logic signed [65:0] prod;
        prod = 66'(p) * 66'(q);
        return prod >>> FRAC;
    endfunction

    function automatic logic signed [31:0] fx_div(input logic signed [31:0] n,
                                                  input logic signed [31:0] m);
        logic signed [65:0] wide;
        if (m == 0) begin
            sys_err = 1;
            if (n > 0) return 32'sh7FFF_FFFF;
            if (n < 0) return 32'sh8000_0000;
            return 32'sd0;
        end
        wide = (66'(n) <<< FRAC) / 66'(m);
        return clamp(wide);
    endfunction

    // forward sweep for one row, back substitution on the last one
    task automatic sweep_row(input t_row r);
        logic signed [31:0] a, c, piv, num, cpv, dpv;
        logic signed [31:0] xs [NROWS];
        int  pos;
        bit  fin;
        t_sol s;
        pos = rows_taken;
        fin = r.last || (pos >= NROWS - 1);
        a = (pos == 0) ? 32'sd0 : r.a;
        c = fin ? 32'sd0 : r.c;
        piv = clamp(66'(r.b) - fx_mul(carry_cp, a));
        num = clamp(66'(r.d) - fx_mul(carry_dp, a));
        cpv = fx_div(c, piv);
        dpv = fx_div(num, piv);
        cp_mem[pos] = cpv;
        dp_mem[pos] = dpv;
        carry_cp = cpv;
        carry_dp = dpv;
        if (!fin) begin
            rows_taken = pos + 1;
            return;
        end
        xs[pos] = dp_mem[pos];
        for (int i = pos - 1; i >= 0; i--)
            xs[i] = clamp(66'(dp_mem[i]) - fx_mul(cp_mem[i], xs[i+1]));
        for (int i = pos; i >= 0; i--) begin
            s.idx = i[5:0];
            s.x = xs[i];
            s.lastres = (i == 0);
            s.err = sys_err;
            expected_sols.push_back(s);
        end
        rows_taken = 0;
        carry_cp = 0;
        carry_dp = 0;
        sys_err = 0;
        systems_done++;
    endtask

    function automatic logic [31:0] rnd_val(input int mode);
        case (mode)
            0: return $urandom;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h0;
            default: return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
        endcase
    endfunction

    function automatic t_row mk_row(input bit dominant, input bit lst);
        t_row r;
        if (dominant) begin
            r.a = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
            r.c = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
            r.b = $urandom_range(32'h0003_0000, 32'h0008_0000);
            if ($urandom_range(0, 1)) r.b = -r.b;
            r.d = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
        end else begin
            r.a = rnd_val($urandom_range(0, 5));
            r.b = rnd_val($urandom_range(0, 5));
            r.c = rnd_val($urandom_range(0, 5));
            r.d = rnd_val($urandom_range(0, 5));
        end
        r.last = lst;
        return r;
    endfunction

    // stimulus: directed systems, then random systems of mostly small size
    initial begin
        t_row r;
        int len;
        bit noisy;
        // single-row system with extremes
        r = '{a: 32'sh8000_0000, b: 32'sh0001_0000, c: 32'sh7FFF_FFFF,
              d: 32'sh7FFF_FFFF, last: 1'b1};
        pending_rows.push_back(r);
        // zero pivots: positive, negative and zero numerators
        r = '{a: 0, b: 0, c: 32'sh0001_0000, d: 32'sh0001_0000, last: 1'b1};
        pending_rows.push_back(r);
        r = '{a: 0, b: 0, c: 32'sh8000_0000, d: 32'sh8000_0000, last: 1'b1};
        pending_rows.push_back(r);
        r = '{a: 0, b: 0, c: 0, d: 0, last: 1'b1};
        pending_rows.push_back(r);
        // a two-row system with saturation through a tiny pivot
        r = '{a: 32'sh7FFF_FFFF, b: 32'sh0000_0001, c: 32'sh7FFF_FFFF,
              d: 32'shFFFF_FFFF, last: 1'b0};
        pending_rows.push_back(r);
        r = '{a: 32'sh7FFF_FFFF, b: 32'sh8000_0000, c: 32'sh7FFF_FFFF,
              d: 32'sh7FFF_FFFF, last: 1'b1};
        pending_rows.push_back(r);
        // a well-behaved three-row system
        for (int i = 0; i < 3; i++) pending_rows.push_back(mk_row(1, i == 2));
        // row limit: 64 rows without last_row set
        for (int i = 0; i < NROWS; i++) pending_rows.push_back(mk_row(1, 1'b0));
        // random systems
        while (pending_rows.size() < 220) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20)
                                              : $urandom_range(1, 6);
            noisy = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < len; i++)
                pending_rows.push_back(mk_row(!noisy, i == len - 1));
        end
        stimulus_done = 1;
    end

    // row driver
    int src_gap = 0;
    initial begin
        row_bus.valid = 1'b0;
        row_bus.sub_diag = '0;
        row_bus.main_diag = '0;
        row_bus.super_diag = '0;
        row_bus.rhs_value = '0;
        row_bus.last_row = 1'b0;
        res_bus.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            row_bus.valid <= 1'b0;
            src_gap <= 0;
        end else if (row_bus.valid && !row_bus.ready) begin
            // hold the offered beat
        end else begin
            if (row_bus.valid) begin
                sweep_row(pending_rows.pop_front());
                rows_sent++;
            end
            if (src_gap > 0) begin
                row_bus.valid <= 1'b0;
                src_gap <= src_gap - 1;
            end else if (pending_rows.size() > 0) begin
                t_row nx;
                nx = pending_rows[0];
                row_bus.valid <= 1'b1;
                row_bus.sub_diag <= nx.a;
                row_bus.main_diag <= nx.b;
                row_bus.super_diag <= nx.c;
                row_bus.rhs_value <= nx.d;
                row_bus.last_row <= nx.last;
                src_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 6) : 0;
            end else begin
                row_bus.valid <= 1'b0;
            end
        end
    end

    // result monitor with random stalls
    int snk_gap = 0;
    bit long_done = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                t_sol got, want;
                got = '{idx: res_bus.row_index, x: res_bus.solution,
                        lastres: res_bus.last_result, err: res_bus.error_seen};
                sols_seen++;
                if (expected_sols.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected solution beat: row %0d x %0d", got.idx, got.x);
                end else begin
                    want = expected_sols.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp row %0d x %0d last %0b err %0b,",
                                      " got row %0d x %0d last %0b err %0b"},
                                     want.idx, want.x, want.lastres, want.err,
                                     got.idx, got.x, got.lastres, got.err);
                    end
                end
            end
            if (hold_off > 0) begin
                res_bus.ready <= 1'b0;
            end else if (snk_gap > 0) begin
                res_bus.ready <= 1'b0;
                snk_gap <= snk_gap - 1;
            end else begin
                res_bus.ready <= 1'b1;
                if (res_bus.valid && res_bus.ready)
                    snk_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 6) : 0;
            end
        end
    end

    // one long receiver hold-off, counted on its own
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_off <= 0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
        end else if (!long_done && systems_done == 8) begin
            long_done <= 1'b1;
            hold_off <= 2000;
        end
    end

    // watchdog on cycles without any accepted beat, outside the receiver hold-off
    always @(posedge i_clk) begin
        if ((row_bus.valid && row_bus.ready) || (res_bus.valid && res_bus.ready)
            || hold_off > 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        carry_cp = 0;
        carry_dp = 0;
        rows_taken = 0;
        sys_err = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            begin
                wait (stimulus_done && pending_rows.size() == 0 && !row_bus.valid
                      && expected_sols.size() == 0);
                repeat (200) @(posedge i_clk);
            end
            begin
                wait (idle_cycles >= WATCHDOG);
                $display("timeout: no beat accepted for %0d cycles", WATCHDOG);
                $display("tridiagonal_system_solver_tb failed");
                $finish;
            end
        join_any
        $display("covered %0d rows in %0d systems, %0d solution beats checked",
                 rows_sent, systems_done, sols_seen);
        if (mismatches == 0 && expected_sols.size() == 0) begin
            $display("tridiagonal_system_solver_tb passed");
        end else begin
            $display("%0d mismatches, %0d beats outstanding", mismatches,
                     expected_sols.size());
            $display("tridiagonal_system_solver_tb failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
hdl/tsolv_pkg.sv
hdl/tsolv_if.sv
hdl/tsolv_ram.sv
hdl/tsolv_div.sv
hdl/tridiagonal_system_solver.sv
sim/tridiagonal_system_solver_tb.sv
